FILE: design/adc_avg_pkg.sv
// Package for the averaging converter front end: widths, codes, register
// indexes and the structs passed between the front, queue, back and divider.
// No dependencies.
package adc_avg_pkg;

   localparam int RAW_W      = 24;
   localparam int SUM_W      = 32;
   localparam int AVG_W      = 25;
   localparam int CNT_W      = 7;
   localparam int LEFT_W     = CNT_W + 1;
   localparam int TMO_W      = 10;
   localparam int OP_W       = 2;
   localparam int DIV_W      = SUM_W + 1;
   localparam int DIV_CW     = $clog2(DIV_W + 1);
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = TMO_W;

   // depth must be a power of two
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

   localparam logic [OP_W-1:0] OP_START  = 2'd0;
   localparam logic [OP_W-1:0] OP_SAMPLE = 2'd1;
   localparam logic [OP_W-1:0] OP_TICK   = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLE_COUNT  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CALIBRATE     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT_TICKS = 2'd2;

   localparam logic [CNT_W-1:0] SAMPLE_COUNT_RST  = 7'd1;
   localparam logic [TMO_W-1:0] TIMEOUT_TICKS_RST = 10'd200;

   localparam logic STATUS_DONE    = 1'b0;
   localparam logic STATUS_TIMEOUT = 1'b1;

   typedef enum logic [1:0] {
      CMD_START  = 2'd0,
      CMD_SAMPLE = 2'd1,
      CMD_TICK   = 2'd2
   } cmd_type;

   typedef struct packed {
      cmd_type           cmd;
      logic [SUM_W-1:0]  sample;
   } q_entry_type;

   typedef struct packed {
      logic [CNT_W-1:0]  sample_count;
      logic              calibrate;
      logic [TMO_W-1:0]  timeout_ticks;
   } cfg_type;

   typedef struct packed {
      logic                     start;
      logic signed [DIV_W-1:0]  dividend;
      logic [CNT_W-1:0]         divisor;
   } div_req_type;

   typedef struct packed {
      logic                     busy;
      logic                     done;
      logic signed [AVG_W-1:0]  quotient;
   } div_rsp_type;

endpackage

FILE: design/adc_avg_if.sv
// Valid/ready channel interfaces for the request, result and register
// write ports. Depends on adc_avg_pkg.
interface adc_avg_req_if;
   logic                                valid;
   logic                                ready;
   logic [adc_avg_pkg::OP_W-1:0]        operation;
   logic [adc_avg_pkg::RAW_W-1:0]       raw_sample;

   modport source (output valid, output operation, output raw_sample, input ready);
   modport sink   (input valid, input operation, input raw_sample, output ready);
endinterface

interface adc_avg_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [adc_avg_pkg::AVG_W-1:0] average;
   logic                                status;

   modport source (output valid, output average, output status, input ready);
   modport sink   (input valid, input average, input status, output ready);
endinterface

interface adc_avg_csr_if;
   logic                                valid;
   logic                                ready;
   logic [adc_avg_pkg::CSR_IDX_W-1:0]   index;
   logic [adc_avg_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: design/adc_average_with_offset_cal.sv
// Averaging front end for a 24-bit converter with offset calibration.
// Channels: req_ch takes beats of operation (start, sample, tick) and
// raw_sample; rsp_ch gives average and status (0 done, 1 timeout); csr_ch
// writes sample_count (0), calibrate (1) and timeout_ticks (2), always ready.
// Writes must be made with no measurement in flight; the block itself does
// not enforce it. A four-entry command queue sits between the front end and
// the sequencer, so request beats are taken while a result waits on rsp_ch.
// Throughput: one command per cycle through the sequencer, except while the
// divider runs or a result waits on rsp_ch. The last sample of the main
// phase starts the restoring divider (one quotient bit a cycle); its result
// goes out when done. A timeout result appears the cycle after its tick.
// If rsp_ch stalls, the sequencer holds and the queue fills, then req_ch
// ready drops. Reset (synchronous, active high) empties the queue, drops any
// measurement and result and restores sample_count 1, calibrate 0 and
// timeout_ticks 200. Depends on adc_avg_pkg, adc_avg_if and all submodules.
module adc_average_with_offset_cal (
   input  logic           clock,
   input  logic           reset,
   adc_avg_req_if.sink    req_ch,
   adc_avg_rsp_if.source  rsp_ch,
   adc_avg_csr_if.sink    csr_ch
);
   import adc_avg_pkg::*;

   cfg_type      cfg_ff;
   logic         q_push, q_pop, q_full, q_not_empty;
   q_entry_type  q_entry, q_head;
   div_req_type  div_req;
   div_rsp_type  div_rsp;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sample_count  <= SAMPLE_COUNT_RST;
         cfg_ff.calibrate     <= 1'b0;
         cfg_ff.timeout_ticks <= TIMEOUT_TICKS_RST;
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            CSR_SAMPLE_COUNT:  cfg_ff.sample_count  <= csr_ch.data[CNT_W-1:0];
            CSR_CALIBRATE:     cfg_ff.calibrate     <= csr_ch.data[0];
            CSR_TIMEOUT_TICKS: cfg_ff.timeout_ticks <= csr_ch.data[TMO_W-1:0];
            default: ;
         endcase
      end
   end

   adc_avg_front u_front (
      .req     (req_ch),
      .q_full  (q_full),
      .q_push  (q_push),
      .q_entry (q_entry)
   );

   adc_avg_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .pop        (q_pop),
      .full       (q_full),
      .not_empty  (q_not_empty),
      .head       (q_head)
   );

   adc_avg_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   adc_avg_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .q_not_empty (q_not_empty),
      .q_head      (q_head),
      .q_pop       (q_pop),
      .div_req     (div_req),
      .div_rsp     (div_rsp),
      .rsp         (rsp_ch)
   );

   a_done_slot_free: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> !rsp_ch.valid)
      else $error("divider finished while a result beat was pending");

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !div_rsp.busy)
      else $error("divider restarted while busy");

   a_no_pop_div: assert property (@(posedge clock) disable iff (reset)
      div_rsp.busy |-> !q_pop)
      else $error("command taken during division");

   a_timeout_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.status == STATUS_TIMEOUT) |-> rsp_ch.average == '0)
      else $error("timeout beat with non-zero average");

endmodule

FILE: design/adc_avg_front.sv
// Front end: takes request beats, drops unused codes, sign-extends samples
// and pushes commands into the queue. Depends on adc_avg_pkg, adc_avg_if.
module adc_avg_front (
   adc_avg_req_if.sink               req,
   input  logic                      q_full,
   output logic                      q_push,
   output adc_avg_pkg::q_entry_type  q_entry
);
   import adc_avg_pkg::*;

   logic known;

   assign req.ready = !q_full;

   always_comb begin
      known          = 1'b1;
      q_entry.cmd    = CMD_START;
      q_entry.sample = {{(SUM_W - RAW_W){req.raw_sample[RAW_W-1]}}, req.raw_sample};
      case (req.operation)
         OP_START:  q_entry.cmd = CMD_START;
         OP_SAMPLE: q_entry.cmd = CMD_SAMPLE;
         OP_TICK:   q_entry.cmd = CMD_TICK;
         default:   known = 1'b0;
      endcase
   end

   assign q_push = req.valid && !q_full && known;

endmodule

FILE: design/adc_avg_queue.sv
// Short command queue between front and back.
// Depends on adc_avg_pkg.
module adc_avg_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  adc_avg_pkg::q_entry_type  push_entry,
   input  logic                      pop,
   output logic                      full,
   output logic                      not_empty,
   output adc_avg_pkg::q_entry_type  head
);
   import adc_avg_pkg::*;

   q_entry_type          mem_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CW-1:0]  count_ff, count_in;
   logic                 do_push, do_pop;

   assign full      = (count_ff == QUEUE_CW'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = mem_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QUEUE_AW'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + QUEUE_AW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + QUEUE_CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QUEUE_CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

FILE: design/adc_avg_div.sv
// Radix-2 restoring divider, one quotient bit per cycle, truncating toward
// zero; signed 33-bit dividend by 7-bit count. Depends on adc_avg_pkg.
module adc_avg_div (
   input  logic                      clock,
   input  logic                      reset,
   input  adc_avg_pkg::div_req_type  div_req,
   output adc_avg_pkg::div_rsp_type  div_rsp
);
   import adc_avg_pkg::*;

   logic                     busy_ff, done_ff;
   logic [DIV_CW-1:0]        cnt_ff;
   logic                     neg_ff;
   logic [DIV_W-1:0]         quo_ff;
   logic [CNT_W-1:0]         rem_ff;
   logic [CNT_W-1:0]         dvs_ff;
   logic signed [AVG_W-1:0]  res_ff;

   logic [DIV_W-1:0]         mag;
   logic [CNT_W:0]           trial, trial_sub;
   logic                     ge;
   logic [CNT_W-1:0]         rem_in;
   logic [DIV_W-1:0]         quo_in;
   logic signed [AVG_W-1:0]  res_in;

   always_comb begin
      mag       = div_req.dividend[DIV_W-1] ? (~div_req.dividend) + DIV_W'(1)
                                            : div_req.dividend;
      trial     = {rem_ff, quo_ff[DIV_W-1]};
      trial_sub = trial - {1'b0, dvs_ff};
      ge        = (trial >= {1'b0, dvs_ff});
      rem_in    = ge ? trial_sub[CNT_W-1:0] : trial[CNT_W-1:0];
      quo_in    = {quo_ff[DIV_W-2:0], ge};
      res_in    = neg_ff ? AVG_W'(0) - quo_in[AVG_W-1:0] : quo_in[AVG_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (div_req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= DIV_CW'(DIV_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - DIV_CW'(1);
            if (cnt_ff == DIV_CW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (div_req.start) begin
         neg_ff <= div_req.dividend[DIV_W-1];
         quo_ff <= mag;
         rem_ff <= '0;
         dvs_ff <= div_req.divisor;
      end else if (busy_ff) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
         if (cnt_ff == DIV_CW'(1)) begin
            res_ff <= res_in;
         end
      end
   end

   assign div_rsp.busy     = busy_ff;
   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = res_ff;

endmodule

FILE: design/adc_avg_back.sv
// Back end: measurement sequencer. Runs queued commands one a cycle unless
// dividing or holding a result; keeps the phase sums and wait count, drives
// the divider and the result register. Depends on adc_avg_pkg, adc_avg_if.
module adc_avg_back (
   input  logic                      clock,
   input  logic                      reset,
   input  adc_avg_pkg::cfg_type      cfg,
   input  logic                      q_not_empty,
   input  adc_avg_pkg::q_entry_type  q_head,
   output logic                      q_pop,
   output adc_avg_pkg::div_req_type  div_req,
   input  adc_avg_pkg::div_rsp_type  div_rsp,
   adc_avg_rsp_if.source             rsp
);
   import adc_avg_pkg::*;

   typedef enum logic [3:0] {
      BK_IDLE   = 4'b0001,
      BK_OFFSET = 4'b0010,
      BK_MAIN   = 4'b0100,
      BK_DIV    = 4'b1000
   } bk_state_type;

   bk_state_type             state_ff, state_in;
   logic [LEFT_W-1:0]        left_ff, left_in;
   logic                     disc_ff, disc_in;
   logic [SUM_W-1:0]         run_ff, run_in;
   logic [SUM_W-1:0]         ofs_ff, ofs_in;
   logic [TMO_W-1:0]         wait_ff, wait_in;
   logic                     out_vld_ff, out_vld_in;
   logic signed [AVG_W-1:0]  avg_ff, avg_in;
   logic                     status_ff, status_in;

   logic [CNT_W-1:0]         n_eff;
   logic                     multi;
   logic [LEFT_W-1:0]        left_load;
   logic [TMO_W-1:0]         limit;
   logic [TMO_W-1:0]         wait_inc;
   logic [SUM_W-1:0]         sum_new;
   logic [LEFT_W-1:0]        left_new;
   logic                     active;

   always_comb begin
      n_eff     = (cfg.sample_count == '0) ? CNT_W'(1) : cfg.sample_count;
      multi     = (n_eff > CNT_W'(1));
      left_load = multi ? {1'b0, n_eff} + LEFT_W'(1) : {1'b0, n_eff};
      limit     = (cfg.timeout_ticks == '0) ? TMO_W'(1) : cfg.timeout_ticks;
      wait_inc  = wait_ff + TMO_W'(1);
      sum_new   = disc_ff ? run_ff : run_ff + q_head.sample;
      left_new  = (left_ff != '0) ? left_ff - LEFT_W'(1) : left_ff;
      active    = (state_ff == BK_OFFSET) || (state_ff == BK_MAIN);
   end

   always_comb begin
      state_in         = state_ff;
      left_in          = left_ff;
      disc_in          = disc_ff;
      run_in           = run_ff;
      ofs_in           = ofs_ff;
      wait_in          = wait_ff;
      out_vld_in       = out_vld_ff && !rsp.ready;
      avg_in           = avg_ff;
      status_in        = status_ff;
      q_pop            = 1'b0;
      div_req.start    = 1'b0;
      div_req.dividend = {sum_new[SUM_W-1], sum_new} - {ofs_ff[SUM_W-1], ofs_ff};
      div_req.divisor  = n_eff;

      if (state_ff == BK_DIV) begin
         if (div_rsp.done) begin
            out_vld_in = 1'b1;
            avg_in     = div_rsp.quotient;
            status_in  = STATUS_DONE;
            state_in   = BK_IDLE;
         end
      end else if (q_not_empty && !out_vld_ff) begin
         q_pop = 1'b1;
         case (q_head.cmd)
            CMD_START: begin
               ofs_in   = '0;
               state_in = cfg.calibrate ? BK_OFFSET : BK_MAIN;
               left_in  = left_load;
               disc_in  = multi;
               run_in   = '0;
               wait_in  = '0;
            end
            CMD_TICK: begin
               if (active) begin
                  if (wait_inc >= limit) begin
                     state_in   = BK_IDLE;
                     left_in    = '0;
                     disc_in    = 1'b0;
                     wait_in    = '0;
                     out_vld_in = 1'b1;
                     avg_in     = '0;
                     status_in  = STATUS_TIMEOUT;
                  end else begin
                     wait_in = wait_inc;
                  end
               end
            end
            CMD_SAMPLE: begin
               if (active) begin
                  wait_in = '0;
                  disc_in = 1'b0;
                  run_in  = sum_new;
                  left_in = left_new;
                  if (left_new == '0) begin
                     if (state_ff == BK_OFFSET) begin
                        ofs_in   = sum_new;
                        state_in = BK_MAIN;
                        left_in  = left_load;
                        disc_in  = multi;
                        run_in   = '0;
                     end else begin
                        div_req.start = 1'b1;
                        state_in      = BK_DIV;
                     end
                  end
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= BK_IDLE;
         out_vld_ff <= 1'b0;
         left_ff    <= '0;
         disc_ff    <= 1'b0;
         wait_ff    <= '0;
      end else begin
         state_ff   <= state_in;
         out_vld_ff <= out_vld_in;
         left_ff    <= left_in;
         disc_ff    <= disc_in;
         wait_ff    <= wait_in;
      end
   end

   always_ff @(posedge clock) begin
      run_ff    <= run_in;
      ofs_ff    <= ofs_in;
      avg_ff    <= avg_in;
      status_ff <= status_in;
   end

   assign rsp.valid   = out_vld_ff;
   assign rsp.average = avg_ff;
   assign rsp.status  = status_ff;

endmodule
